// ===== hdl/lrpb_pkg.sv =====
// shared types and constants for the line rasterizer page buffer
// no dependencies; imported by every module of the block except lrpb_ram
package lrpb_pkg;

   typedef enum logic [1:0] {
      OP_SOLID  = 2'd0,
      OP_DASHED = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_DASH_LENGTH = 2'd0,
      CSR_GAP_LENGTH  = 2'd1
   } csr_index_type;

   localparam logic [3:0] DASH_RESET = 4'd3;
   localparam logic [3:0] GAP_RESET  = 4'd2;

   localparam int QUEUE_DEPTH = 2;

   typedef logic signed [10:0] coord_in_type;
   typedef logic signed [11:0] coord_type;
   typedef logic signed [14:0] err_type;

   typedef struct packed {
      logic [3:0] dash_length;
      logic [3:0] gap_length;
   } dash_cfg_type;

   // decoded command as handed from the front end to the draw engine
   typedef struct packed {
      opcode_type opcode;
      coord_type  maj_start;
      coord_type  min_start;
      coord_type  maj_end;
      err_type    err_start;
      err_type    inc_e;
      err_type    inc_ne;
      logic       neg;
      logic       swap;
      logic       read_page;
      logic [6:0] read_column;
   } cmd_type;

endpackage

// ===== hdl/lrpb_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module lrpb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 192,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      rdata <= mem_ff[raddr];
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

endmodule

// ===== hdl/lrpb_front.sv =====
// front end: takes commands, orders endpoints and sets up the octant
// depends on lrpb_pkg; feeds lrpb_queue
module lrpb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  lrpb_pkg::coord_in_type req_start_x,
   input  lrpb_pkg::coord_in_type req_start_y,
   input  lrpb_pkg::coord_in_type req_end_x,
   input  lrpb_pkg::coord_in_type req_end_y,
   input  logic                  req_read_page,
   input  logic [6:0]            req_read_column,
   input  logic                  sweep_active,
   input  logic                  queue_full,
   output logic                  push,
   output lrpb_pkg::cmd_type     push_cmd
);
   import lrpb_pkg::*;

   logic         accept;
   logic         eq_x, gt_x, gt_y, lt_y, swap_ends, falling;
   coord_in_type ox0, ox1, oy0, oy1;

   logic         a_valid_ff, a_valid_in;
   opcode_type   a_opcode_ff;
   coord_in_type a_x0_ff, a_x1_ff;
   coord_type    a_y0_ff, a_y1_ff;
   logic         a_neg_ff;
   logic         a_page_ff;
   logic [6:0]   a_column_ff;

   coord_type    dx, dy, dmaj, dmin;
   logic         steep;
   err_type      two_dmin, two_dmaj;

   assign busy   = sweep_active || (a_valid_ff && queue_full);
   assign accept = start && !busy;
   assign push   = a_valid_ff && !queue_full;

   // endpoint order: by row for vertical lines, by column otherwise
   always_comb begin
      eq_x      = req_start_x == req_end_x;
      gt_x      = req_start_x > req_end_x;
      gt_y      = req_start_y > req_end_y;
      lt_y      = req_start_y < req_end_y;
      swap_ends = eq_x ? gt_y : gt_x;
      ox0       = swap_ends ? req_end_x : req_start_x;
      ox1       = swap_ends ? req_start_x : req_end_x;
      oy0       = swap_ends ? req_end_y : req_start_y;
      oy1       = swap_ends ? req_start_y : req_end_y;
      falling   = swap_ends ? lt_y : gt_y;
   end

   assign a_valid_in = accept || (a_valid_ff && queue_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (accept) begin
         a_opcode_ff <= opcode_type'(req_opcode);
         a_x0_ff     <= ox0;
         a_x1_ff     <= ox1;
         a_y0_ff     <= falling ? -coord_type'(oy0) : coord_type'(oy0);
         a_y1_ff     <= falling ? -coord_type'(oy1) : coord_type'(oy1);
         a_neg_ff    <= falling;
         a_page_ff   <= req_read_page;
         a_column_ff <= req_read_column;
      end
   end

   // axis swap for steep lines and error term setup
   always_comb begin
      dx       = coord_type'(a_x1_ff) - coord_type'(a_x0_ff);
      dy       = a_y1_ff - a_y0_ff;
      steep    = dy > dx;
      dmaj     = steep ? dy : dx;
      dmin     = steep ? dx : dy;
      two_dmin = err_type'(dmin) + err_type'(dmin);
      two_dmaj = err_type'(dmaj) + err_type'(dmaj);

      push_cmd.opcode      = a_opcode_ff;
      push_cmd.maj_start   = steep ? a_y0_ff : coord_type'(a_x0_ff);
      push_cmd.min_start   = steep ? coord_type'(a_x0_ff) : a_y0_ff;
      push_cmd.maj_end     = steep ? a_y1_ff : coord_type'(a_x1_ff);
      push_cmd.err_start   = two_dmin - err_type'(dmaj);
      push_cmd.inc_e       = two_dmin;
      push_cmd.inc_ne      = two_dmin - two_dmaj;
      push_cmd.neg         = a_neg_ff;
      push_cmd.swap        = steep;
      push_cmd.read_page   = a_page_ff;
      push_cmd.read_column = a_column_ff;
   end

endmodule

// ===== hdl/lrpb_queue.sv =====
// short command queue between the front end and the draw engine
// depends on lrpb_pkg
module lrpb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lrpb_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output lrpb_pkg::cmd_type pop_cmd
);
   import lrpb_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         entries_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full    = count_ff == CW'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

// ===== hdl/lrpb_back.sv =====
// draw engine: steps lines one point a cycle, clears and reads the store
// depends on lrpb_pkg; drives the lrpb_ram frame store
module lrpb_back #(
   parameter int COLUMNS = 96,
   parameter int PAGES = 2,
   parameter int ADDR_W = $clog2(COLUMNS * PAGES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lrpb_pkg::dash_cfg_type dash_cfg,
   input  logic                   queue_empty,
   output logic                   pop,
   input  lrpb_pkg::cmd_type      pop_cmd,
   output logic                   sweep_active,
   output logic                   ram_we,
   output logic [ADDR_W-1:0]      ram_waddr,
   output logic [7:0]             ram_wdata,
   output logic [ADDR_W-1:0]      ram_raddr,
   input  logic [7:0]             ram_rdata,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_read_data
);
   import lrpb_pkg::*;

   localparam int DEPTH = COLUMNS * PAGES;
   localparam int ROWS = PAGES * 8;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_LINE,
      ST_CLEAR,
      ST_READ
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   coord_type         maj_ff, maj_in;
   coord_type         min_ff, min_in;
   err_type           err_ff, err_in;
   logic [4:0]        dash_cnt_ff, dash_cnt_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_we_ff, s1_we_in;
   logic              s1_clear_ff, s1_clear_in;
   logic              s1_read_ff, s1_read_in;
   logic              s1_read_ok_ff, s1_read_ok_in;
   logic              s1_rsp_ff, s1_rsp_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic [7:0]        s1_mask_ff, s1_mask_in;

   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [7:0]        fwd_data_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_data_ff;

   coord_type         px, py_raw, py;
   logic              px_ok, py_ok, dash_draw, line_last, rd_ok;
   logic [ADDR_W-1:0] pt_addr, rd_addr;
   logic [7:0]        pt_mask, rdata_eff;
   logic [4:0]        period, cnt_inc;

   // screen point of the current step, clip and byte address
   always_comb begin
      px        = cmd_ff.swap ? min_ff : maj_ff;
      py_raw    = cmd_ff.swap ? maj_ff : min_ff;
      py        = cmd_ff.neg ? -py_raw : py_raw;
      px_ok     = !px[11] && (32'(px[10:0]) < COLUMNS);
      py_ok     = !py[11] && (32'(py[10:0]) < ROWS);
      pt_addr   = ADDR_W'(ADDR_W'(py[10:3]) * ADDR_W'(COLUMNS) + ADDR_W'(px[10:0]));
      pt_mask   = 8'h01 << py[2:0];
      line_last = maj_ff >= cmd_ff.maj_end;
      period    = 5'(dash_cfg.dash_length) + 5'(dash_cfg.gap_length);
      cnt_inc   = dash_cnt_ff + 5'd1;
      dash_draw = (cmd_ff.opcode != OP_DASHED) ||
                  (dash_cnt_ff < 5'(dash_cfg.dash_length));
      rd_ok     = (32'(cmd_ff.read_page) < PAGES) && (32'(cmd_ff.read_column) < COLUMNS);
      rd_addr   = ADDR_W'(ADDR_W'(cmd_ff.read_page) * ADDR_W'(COLUMNS) +
                          ADDR_W'(cmd_ff.read_column));
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      maj_in        = maj_ff;
      min_in        = min_ff;
      err_in        = err_ff;
      dash_cnt_in   = dash_cnt_ff;
      sweep_addr_in = sweep_addr_ff;
      s1_valid_in   = 1'b0;
      s1_we_in      = 1'b0;
      s1_clear_in   = 1'b0;
      s1_read_in    = 1'b0;
      s1_read_ok_in = 1'b0;
      s1_rsp_in     = 1'b0;
      s1_addr_in    = s1_addr_ff;
      s1_mask_in    = s1_mask_ff;
      pop           = 1'b0;
      case (state_ff)
         ST_SWEEP, ST_CLEAR: begin
            s1_valid_in = 1'b1;
            s1_we_in    = 1'b1;
            s1_clear_in = 1'b1;
            s1_addr_in  = sweep_addr_ff;
            if (sweep_addr_ff == ADDR_W'(DEPTH - 1)) begin
               s1_rsp_in     = state_ff == ST_CLEAR;
               sweep_addr_in = '0;
               state_in      = ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               pop           = 1'b1;
               cmd_in        = pop_cmd;
               maj_in        = pop_cmd.maj_start;
               min_in        = pop_cmd.min_start;
               err_in        = pop_cmd.err_start;
               dash_cnt_in   = '0;
               sweep_addr_in = '0;
               case (pop_cmd.opcode)
                  OP_SOLID, OP_DASHED: state_in = ST_LINE;
                  OP_CLEAR:            state_in = ST_CLEAR;
                  OP_READ:             state_in = ST_READ;
                  default:             state_in = ST_IDLE;
               endcase
            end
         end
         ST_LINE: begin
            s1_valid_in = 1'b1;
            s1_we_in    = px_ok && py_ok && dash_draw;
            s1_addr_in  = pt_addr;
            s1_mask_in  = pt_mask;
            if ((cmd_ff.opcode == OP_DASHED) && (period != '0)) begin
               dash_cnt_in = (cnt_inc >= period) ? '0 : cnt_inc;
            end
            if (line_last) begin
               s1_rsp_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               maj_in = maj_ff + 1'b1;
               // negative error takes the east step, otherwise diagonal
               if (err_ff[$bits(err_type)-1]) begin
                  err_in = err_ff + cmd_ff.inc_e;
               end else begin
                  min_in = min_ff + 1'b1;
                  err_in = err_ff + cmd_ff.inc_ne;
               end
            end
         end
         ST_READ: begin
            s1_valid_in   = 1'b1;
            s1_read_in    = 1'b1;
            s1_read_ok_in = rd_ok;
            s1_addr_in    = rd_addr;
            s1_rsp_in     = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ram_raddr = s1_addr_in;

   // read-modify-write; the previous cycle's write is forwarded past the ram
   always_comb begin
      rdata_eff = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rdata;
      ram_we    = s1_valid_ff && s1_we_ff;
      ram_waddr = s1_addr_ff;
      ram_wdata = s1_clear_ff ? 8'h00 : (rdata_eff | s1_mask_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s1_we_ff      <= 1'b0;
         s1_rsp_ff     <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_addr_ff <= sweep_addr_in;
         s1_valid_ff   <= s1_valid_in;
         s1_we_ff      <= s1_we_in;
         s1_rsp_ff     <= s1_rsp_in;
         fwd_valid_ff  <= ram_we;
         rsp_valid_ff  <= s1_valid_ff && s1_rsp_ff;
      end
      cmd_ff        <= cmd_in;
      maj_ff        <= maj_in;
      min_ff        <= min_in;
      err_ff        <= err_in;
      dash_cnt_ff   <= dash_cnt_in;
      s1_clear_ff   <= s1_clear_in;
      s1_read_ff    <= s1_read_in;
      s1_read_ok_ff <= s1_read_ok_in;
      s1_addr_ff    <= s1_addr_in;
      s1_mask_ff    <= s1_mask_in;
      fwd_addr_ff   <= s1_addr_ff;
      fwd_data_ff   <= ram_wdata;
      rsp_data_ff   <= (s1_read_ff && s1_read_ok_ff) ? rdata_eff : 8'h00;
   end

   assign sweep_active  = state_ff == ST_SWEEP;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back result strobes");

   a_no_pop_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !pop)
      else $error("command taken during reset clear");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_read_ff) |-> !ram_we)
      else $error("read command wrote the store");

endmodule

// ===== hdl/line_rasterizer_page_buffer.sv =====
// line rasterizer over a page-organized monochrome frame store
// depends on lrpb_pkg, lrpb_front, lrpb_queue, lrpb_back, lrpb_ram
// command path: front end register, queue, draw engine, store stage, result register
// throughput: draw engine steps a line one point per cycle through the store's
// read-modify-write and returns to idle between commands; clear sweeps every byte
// reset: clear pass over the whole store with busy high; results are strobes
module line_rasterizer_page_buffer #(
   parameter int COLUMNS = 96,
   parameter int PAGES = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   // command beat
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_opcode,
   input  lrpb_pkg::coord_in_type req_start_x,
   input  lrpb_pkg::coord_in_type req_start_y,
   input  lrpb_pkg::coord_in_type req_end_x,
   input  lrpb_pkg::coord_in_type req_end_y,
   input  logic                   req_read_page,
   input  logic [6:0]             req_read_column,
   // result beat
   output logic                   rsp_valid,
   output logic [7:0]             rsp_read_data,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [3:0]             csr_data
);
   import lrpb_pkg::*;

   localparam int DEPTH = COLUMNS * PAGES;
   localparam int ADDR_W = $clog2(DEPTH);

   // dash registers
   logic [3:0]   dash_length_ff;
   logic [3:0]   gap_length_ff;
   dash_cfg_type dash_cfg;

   // front end to queue
   logic    push, queue_full;
   cmd_type push_cmd;

   // queue to draw engine
   logic    pop, queue_empty;
   cmd_type pop_cmd;
   logic    sweep_active;

   // frame store port
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]        ram_wdata, ram_rdata;

   // registers are always writable; writes to unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dash_length_ff <= DASH_RESET;
         gap_length_ff  <= GAP_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_DASH_LENGTH) begin
            dash_length_ff <= csr_data;
         end
         if (csr_index == CSR_GAP_LENGTH) begin
            gap_length_ff <= csr_data;
         end
      end
   end

   assign dash_cfg.dash_length = dash_length_ff;
   assign dash_cfg.gap_length  = gap_length_ff;

   // front end: endpoint ordering and octant setup, one register stage
   lrpb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_read_page   (req_read_page),
      .req_read_column (req_read_column),
      .sweep_active    (sweep_active),
      .queue_full      (queue_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   // decouples setup from the long-running draw engine
   lrpb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .pop_cmd  (pop_cmd)
   );

   // draw engine: line stepping, clear sweep, byte read
   lrpb_back #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES),
      .ADDR_W  (ADDR_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .dash_cfg      (dash_cfg),
      .queue_empty   (queue_empty),
      .pop           (pop),
      .pop_cmd       (pop_cmd),
      .sweep_active  (sweep_active),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_read_data (rsp_read_data)
   );

   // frame store, page-major, one byte holds 8 rows of a column
   lrpb_ram #(
      .WIDTH  (8),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule
